[hw/rtl/xtte_pkg.sv]
package xtte_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;

  localparam logic [2:0] REPORT_ENABLE_RST = 3'd7;
  localparam logic [7:0] DATE_KEEP_RST     = 8'd17;

  localparam logic CFG_REPORT_ENABLE = 1'b0;
  localparam logic CFG_DATE_KEEP     = 1'b1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] KIND_DATE  = 2'd0;
  localparam logic [1:0] KIND_TITLE = 2'd1;
  localparam logic [1:0] KIND_DESC  = 2'd2;

  localparam logic [7:0] CH_LT  = 8'h3c;
  localparam logic [7:0] CH_GT  = 8'h3e;
  localparam logic [7:0] CH_AMP = 8'h26;

  typedef enum logic [3:0] {
    PH_INIT        = 4'd0,
    PH_WAIT_LT     = 4'd1,
    PH_FIRST       = 4'd2,
    PH_MATCH_DATE  = 4'd3,
    PH_MATCH_TITLE = 4'd4,
    PH_MATCH_DESC  = 4'd5,
    PH_TEXT_DATE   = 4'd6,
    PH_TEXT_TITLE  = 4'd7,
    PH_TEXT_DESC   = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] kw_pos;
  } parse_st_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] text_kind;
    logic [7:0] content_byte;
    logic       end_of_text;
  } result_t;

  // keyword character at a position; zero past the end never matches
  function automatic logic [7:0] kw_char(phase_t phase, logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (phase)
      PH_MATCH_DATE: begin
        case (pos)
          4'd0: c = "p";
          4'd1: c = "u";
          4'd2: c = "b";
          4'd3: c = "D";
          4'd4: c = "a";
          4'd5: c = "t";
          4'd6: c = "e";
          4'd7: c = CH_GT;
          default: c = 8'h00;
        endcase
      end
      PH_MATCH_TITLE: begin
        case (pos)
          4'd0: c = "t";
          4'd1: c = "i";
          4'd2: c = "t";
          4'd3: c = "l";
          4'd4: c = "e";
          4'd5: c = CH_GT;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          4'd0:  c = "d";
          4'd1:  c = "e";
          4'd2:  c = "s";
          4'd3:  c = "c";
          4'd4:  c = "r";
          4'd5:  c = "i";
          4'd6:  c = "p";
          4'd7:  c = "t";
          4'd8:  c = "i";
          4'd9:  c = "o";
          4'd10: c = "n";
          4'd11: c = CH_GT;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/xtte_step.sv]
module xtte_step #(
  parameter int unsigned LENGTH_BITS = xtte_pkg::LENGTH_BITS_DEF
) (
  input  xtte_pkg::parse_st_t   st_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  input  logic                   opcode,
  input  logic [7:0]             text_byte,
  input  logic [2:0]             report_enable,
  input  logic [7:0]             date_keep_length,
  output xtte_pkg::parse_st_t   st_nxt,
  output logic [LENGTH_BITS-1:0] len_nxt,
  output xtte_pkg::result_t     res
);

  logic [1:0]             kind;
  logic                   in_text;
  logic                   enabled;
  logic                   term;
  logic                   nonempty;
  logic                   date_over;
  logic [LENGTH_BITS-1:0] len_inc;

  always_comb begin
    in_text = 1'b1;
    kind    = xtte_pkg::KIND_DATE;
    case (st_i.phase)
      xtte_pkg::PH_TEXT_DATE:  kind = xtte_pkg::KIND_DATE;
      xtte_pkg::PH_TEXT_TITLE: kind = xtte_pkg::KIND_TITLE;
      xtte_pkg::PH_TEXT_DESC:  kind = xtte_pkg::KIND_DESC;
      default:                 in_text = 1'b0;
    endcase
  end

  assign enabled   = report_enable[kind];
  assign term      = (text_byte == xtte_pkg::CH_LT) ||
                     (kind == xtte_pkg::KIND_DESC && text_byte == xtte_pkg::CH_AMP);
  assign nonempty  = (len_i != '0) &&
                     !(kind == xtte_pkg::KIND_DATE && date_keep_length == 8'd0);
  assign date_over = (kind == xtte_pkg::KIND_DATE) &&
                     (len_i >= LENGTH_BITS'(date_keep_length));
  // saturating count of text bytes
  assign len_inc   = (len_i == '1) ? len_i : len_i + LENGTH_BITS'(1);

  // next state
  always_comb begin
    st_nxt  = st_i;
    len_nxt = len_i;
    if (opcode == xtte_pkg::OP_RESTART) begin
      st_nxt.phase  = xtte_pkg::PH_INIT;
      st_nxt.kw_pos = 4'd0;
      len_nxt       = '0;
    end else begin
      unique case (st_i.phase)
        xtte_pkg::PH_INIT: st_nxt.phase = xtte_pkg::PH_WAIT_LT;
        xtte_pkg::PH_WAIT_LT: begin
          if (text_byte == xtte_pkg::CH_LT) st_nxt.phase = xtte_pkg::PH_FIRST;
        end
        xtte_pkg::PH_FIRST: begin
          st_nxt.kw_pos = 4'd1;
          if (text_byte == "p") st_nxt.phase = xtte_pkg::PH_MATCH_DATE;
          else if (text_byte == "t") st_nxt.phase = xtte_pkg::PH_MATCH_TITLE;
          else if (text_byte == "d") st_nxt.phase = xtte_pkg::PH_MATCH_DESC;
          else begin
            st_nxt.phase  = xtte_pkg::PH_WAIT_LT;
            st_nxt.kw_pos = 4'd0;
          end
        end
        xtte_pkg::PH_MATCH_DATE, xtte_pkg::PH_MATCH_TITLE,
        xtte_pkg::PH_MATCH_DESC: begin
          if (text_byte != xtte_pkg::kw_char(st_i.phase, st_i.kw_pos)) begin
            st_nxt.phase  = xtte_pkg::PH_WAIT_LT;
            st_nxt.kw_pos = 4'd0;
          end else if (text_byte == xtte_pkg::CH_GT) begin
            st_nxt.kw_pos = 4'd0;
            len_nxt       = '0;
            case (st_i.phase)
              xtte_pkg::PH_MATCH_DATE:  st_nxt.phase = xtte_pkg::PH_TEXT_DATE;
              xtte_pkg::PH_MATCH_TITLE: st_nxt.phase = xtte_pkg::PH_TEXT_TITLE;
              default:                  st_nxt.phase = xtte_pkg::PH_TEXT_DESC;
            endcase
          end else begin
            st_nxt.kw_pos = st_i.kw_pos + 4'd1;
          end
        end
        xtte_pkg::PH_TEXT_DATE, xtte_pkg::PH_TEXT_TITLE,
        xtte_pkg::PH_TEXT_DESC: begin
          if (term) begin
            st_nxt.phase = xtte_pkg::PH_WAIT_LT;
            len_nxt      = '0;
          end else begin
            len_nxt = len_inc;
          end
        end
        default: begin
          st_nxt.phase  = xtte_pkg::PH_WAIT_LT;
          st_nxt.kw_pos = 4'd0;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res.valid        = 1'b0;
    res.text_kind    = kind;
    res.content_byte = text_byte;
    res.end_of_text  = 1'b0;
    if (opcode == xtte_pkg::OP_BYTE && in_text && enabled) begin
      if (term) begin
        res.valid        = nonempty;
        res.content_byte = 8'h00;
        res.end_of_text  = 1'b1;
      end else begin
        res.valid = !date_over;
      end
    end
  end

endmodule

[hw/rtl/xml_tag_text_extractor.sv]
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall  | in_opcode, in_text_byte
// out     | output    | out_valid/out_stall| out_text_kind, out_content_byte, out_end_of_text
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// one byte per cycle sustained while out_stall is not holding a waiting result; a byte
// is held in the input register and its result is written into the output register
// when the byte advances, which raises out_valid.
// the parse step is a single pass of the tag matcher between those registers.
// rst_n (synchronous) clears the parser to its initial state and the registers
// to their defaults. out_stall holds the output register; the input register
// still takes a byte while a result waits, and in_stall rises only when both are full.
module xml_tag_text_extractor #(
  parameter int unsigned LENGTH_BITS = xtte_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_text_kind,
  output logic [7:0] out_content_byte,
  output logic       out_end_of_text,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [7:0]             s1_byte_r;
  xtte_pkg::parse_st_t    st_r;
  xtte_pkg::parse_st_t    st_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_nxt;
  xtte_pkg::result_t      res;
  logic                   out_valid_r;
  logic [1:0]             out_kind_r;
  logic [7:0]             out_byte_r;
  logic                   out_eot_r;
  logic [2:0]             report_enable_r;
  logic [7:0]             date_keep_r;
  logic                   out_free;
  logic                   adv;
  logic                   in_take;

  xtte_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .st_i             (st_r),
    .len_i            (len_r),
    .opcode           (s1_op_r),
    .text_byte        (s1_byte_r),
    .report_enable    (report_enable_r),
    .date_keep_length (date_keep_r),
    .st_nxt           (st_nxt),
    .len_nxt          (len_nxt),
    .res              (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  // a request with no result never waits on the output side
  assign adv      = s1_valid_r && (!res.valid || out_free);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_text_kind    = out_kind_r;
  assign out_content_byte = out_byte_r;
  assign out_end_of_text  = out_eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r.phase      <= xtte_pkg::PH_INIT;
      st_r.kw_pos     <= 4'd0;
      len_r           <= '0;
      report_enable_r <= xtte_pkg::REPORT_ENABLE_RST;
      date_keep_r     <= xtte_pkg::DATE_KEEP_RST;
    end else begin
      if (in_take) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;

      if (adv) begin
        st_r  <= st_nxt;
        len_r <= len_nxt;
      end

      if (adv && res.valid) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == xtte_pkg::CFG_REPORT_ENABLE) report_enable_r <= cfg_data[2:0];
        else date_keep_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_opcode;
      s1_byte_r <= in_text_byte;
    end
    if (adv && res.valid) begin
      out_kind_r <= res.text_kind;
      out_byte_r <= res.content_byte;
      out_eot_r  <= res.end_of_text;
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import xtte_pkg::*;

  // narrow length counter so that saturation is reached within a short text
  localparam int unsigned TB_LENGTH_BITS = 8;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } text_item_t;

  // tracks the tag parser and holds the text items still owed by the block
  class feed_scoreboard;
    phase_t                    parse_phase = PH_INIT;
    logic [3:0]                kw_pos      = '0;
    logic [TB_LENGTH_BITS-1:0] text_len    = '0;
    logic [2:0]                report_en   = REPORT_ENABLE_RST;
    logic [7:0]                date_keep   = DATE_KEEP_RST;
    text_item_t                text_q[$];
    int errors     = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_ends     = 0;
    int n_restarts = 0;

    function string keyword(logic [1:0] kind);
      case (kind)
        KIND_DATE:  return "pubDate>";
        KIND_TITLE: return "title>";
        default:    return "description>";
      endcase
    endfunction

    function logic [7:0] keyword_byte(logic [1:0] kind, logic [3:0] pos);
      string kw;
      kw = keyword(kind);
      if (int'(pos) < kw.len()) return kw[pos];
      return 8'h00;
    endfunction

    function void set_register(logic idx, logic [7:0] val);
      if (idx == CFG_REPORT_ENABLE) report_en = val[2:0];
      else date_keep = val;
    endfunction

    function void note_request(logic op, logic [7:0] b);
      logic [1:0] kind;
      bit term;
      bit nonempty;
      bit deliver;
      n_requests++;
      if (op == OP_RESTART) begin
        n_restarts++;
        parse_phase = PH_INIT;
        kw_pos      = '0;
        text_len    = '0;
        return;
      end
      case (parse_phase)
        PH_INIT: parse_phase = PH_WAIT_LT;
        PH_WAIT_LT: begin
          if (b == CH_LT) parse_phase = PH_FIRST;
        end
        PH_FIRST: begin
          kw_pos = 4'd1;
          if (b == keyword_byte(KIND_DATE, 4'd0)) parse_phase = PH_MATCH_DATE;
          else if (b == keyword_byte(KIND_TITLE, 4'd0)) parse_phase = PH_MATCH_TITLE;
          else if (b == keyword_byte(KIND_DESC, 4'd0)) parse_phase = PH_MATCH_DESC;
          else begin
            parse_phase = PH_WAIT_LT;
            kw_pos      = '0;
          end
        end
        PH_MATCH_DATE, PH_MATCH_TITLE, PH_MATCH_DESC: begin
          kind = 2'(int'(parse_phase) - int'(PH_MATCH_DATE));
          if (b != keyword_byte(kind, kw_pos)) begin
            parse_phase = PH_WAIT_LT;
            kw_pos      = '0;
          end else begin
            kw_pos = kw_pos + 4'd1;
            if (b == CH_GT) begin
              parse_phase = phase_t'(int'(PH_TEXT_DATE) + int'(kind));
              kw_pos      = '0;
              text_len    = '0;
            end
          end
        end
        PH_TEXT_DATE, PH_TEXT_TITLE, PH_TEXT_DESC: begin
          kind = 2'(int'(parse_phase) - int'(PH_TEXT_DATE));
          term = (b == CH_LT) || (kind == KIND_DESC && b == CH_AMP);
          if (term) begin
            // a date with nothing kept gets no end marker
            nonempty = (text_len != '0) && !(kind == KIND_DATE && date_keep == 8'd0);
            parse_phase = PH_WAIT_LT;
            text_len    = '0;
            if (nonempty && report_en[kind]) text_q.push_back('{kind, 8'h00, 1'b1});
          end else begin
            deliver = report_en[kind] &&
                      !(kind == KIND_DATE && text_len >= TB_LENGTH_BITS'(date_keep));
            if (text_len != '1) text_len = text_len + 1'b1;
            if (deliver) text_q.push_back('{kind, b, 1'b0});
          end
        end
        default: begin
          parse_phase = PH_WAIT_LT;
          kw_pos      = '0;
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      text_item_t want;
      n_results++;
      if (last) n_ends++;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d byte %02h end %0b",
                 $time, kind, data, last);
        errors++;
        return;
      end
      want = text_q.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: text_kind expected %0d got %0d", $time, want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $display("%0t: content_byte expected %02h got %02h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: end_of_text expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return text_q.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_opcode    = OP_BYTE;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_stall    = 1'b0;
  logic       cfg_valid    = 1'b0;
  logic       cfg_index    = CFG_REPORT_ENABLE;
  logic [7:0] cfg_data     = 8'h00;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_text_kind;
  logic [7:0] out_content_byte;
  logic       out_end_of_text;
  logic       cfg_ready;

  feed_scoreboard sb;

  int burst_left   = 0;
  int phase_items  = 0;
  int n_settings   = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stretch_left = 0;
  int stall_pct    = 0;
  int guard;

  xml_tag_text_extractor #(
    .LENGTH_BITS(TB_LENGTH_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_text_kind    (out_text_kind),
    .out_content_byte (out_content_byte),
    .out_end_of_text  (out_end_of_text),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // receiver: stretches of steady stall odds, plus a long hold on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      stretch_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_text_kind, out_content_byte, out_end_of_text);
  end

  task automatic send_byte(logic op, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, b);
    burst_left--;
    phase_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(OP_BYTE, s[i]);
  endtask

  // any byte that does not end text of this kind
  function automatic logic [7:0] plain_byte(logic [1:0] kind);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LT || (kind == KIND_DESC && b == CH_AMP));
    return b;
  endfunction

  task automatic send_element(logic [1:0] kind);
    int len;
    int r;
    repeat ($urandom_range(0, 2)) send_byte(OP_BYTE, plain_byte(KIND_DATE));
    send_byte(OP_BYTE, CH_LT);
    send_text(sb.keyword(kind));
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 10);
    else if (r < 96) len = $urandom_range(11, 40);
    else len = $urandom_range(200, 300);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 199) == 0) begin
        send_byte(OP_RESTART, 8'($urandom));
        return;
      end
      send_byte(OP_BYTE, plain_byte(kind));
    end
    send_byte(OP_BYTE, (kind == KIND_DESC && $urandom_range(0, 1) == 1) ? CH_AMP : CH_LT);
  endtask

  // tag that breaks off partway through its keyword
  task automatic send_broken(logic [1:0] kind);
    string kw;
    int cut;
    logic [7:0] b;
    kw  = sb.keyword(kind);
    cut = $urandom_range(0, kw.len() - 2);
    send_byte(OP_BYTE, CH_LT);
    for (int i = 0; i < cut; i++) send_byte(OP_BYTE, kw[i]);
    if ($urandom_range(0, 3) == 0) b = CH_LT;
    else do b = 8'($urandom_range(0, 255)); while (b == kw[cut]);
    send_byte(OP_BYTE, b);
  endtask

  task automatic random_feed(int target, bit with_hold);
    int r;
    bit held;
    held = 1'b0;
    phase_items = 0;
    while (phase_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_element(2'($urandom_range(0, 2)));
      else if (r < 82) send_broken(2'($urandom_range(0, 2)));
      else if (r < 92) repeat ($urandom_range(1, 8)) send_byte(OP_BYTE, 8'($urandom));
      else send_byte(OP_RESTART, 8'($urandom));
      if (with_hold && !held && phase_items >= 100) begin
        hold_seq++;
        held = 1'b1;
      end
    end
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    // a request that gives no result may still sit in the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic configure(logic [2:0] report, logic [7:0] keep);
    logic [4:0] upper;
    upper = 5'($urandom);
    drain();
    write_register(CFG_REPORT_ENABLE, {upper, report});
    write_register(CFG_DATE_KEEP, keep);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    sb = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(OP_RESTART, 8'hff);
    send_text("<");                          // swallowed after restart
    send_text("<title>");
    send_byte(OP_BYTE, 8'h00);
    send_byte(OP_BYTE, 8'hff);
    send_text("<");
    send_text("<ti<title>Q");                // '<' inside a keyword does not open a tag
    send_text("<title><");                   // empty text
    send_text("<pubDate>ab<");
    send_text("<description>x&");
    send_text("<title>Z");
    send_byte(OP_RESTART, 8'h00);            // abandons the title, no end item
    send_text("<<description>y<");

    random_feed(180, 1'b1);
    configure(3'd0, 8'd0);
    random_feed(50, 1'b0);
    configure(3'd5, 8'd255);
    random_feed(120, 1'b0);
    configure(3'd2, 8'd1);
    random_feed(70, 1'b0);
    configure(3'd7, 8'd0);
    random_feed(90, 1'b0);
    configure(3'd3, 8'd5);
    random_feed(60, 1'b0);

    // date text past the length counter range: a wrap would deliver bytes again
    configure(REPORT_ENABLE_RST, DATE_KEEP_RST);
    send_byte(OP_RESTART, 8'h00);
    send_byte(OP_BYTE, 8'h00);
    send_text("<pubDate>");
    repeat (265) send_byte(OP_BYTE, plain_byte(KIND_DATE));
    send_byte(OP_BYTE, CH_LT);
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d text items never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("tb: %0d requests (%0d restarts), %0d results of which %0d text ends",
             sb.n_requests, sb.n_restarts, sb.n_results, sb.n_ends);
    $display("tb: %0d register settings beyond reset, one date text past the length range",
             n_settings);
    if (sb.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("tb: done, errors");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/xtte_pkg.sv
hw/rtl/xtte_step.sv
hw/rtl/xml_tag_text_extractor.sv
verif/tb.sv
